### rtl/core/dhpca_pkg.sv
// Shared constants, types and address permutations of the coprocessor host port.
`timescale 1ns / 1ps
`default_nettype none
package dhpca_pkg;

    localparam int RAM_WORDS_DEFAULT = 65536;

    localparam int DATA_W = 16;
    localparam int ADDR_W = 24;
    localparam int MODE_W = 2;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // Access modes.
    localparam logic [MODE_W-1:0] MODE_RD16 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RD8  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WR16 = 2'd2;

    // Address decode: upper bits of the byte address for each region.
    localparam logic [6:0]  RAM_BASE_HI  = 7'h18;     // 0x300000-0x31ffff
    localparam logic [7:0]  RAM_LOW_HI   = 8'h30;     // 0x300000-0x30ffff
    localparam logic [7:0]  ARR1_HI      = 8'h39;
    localparam logic [7:0]  ARR2_HI      = 8'h3a;
    localparam logic [19:0] WIN_HI       = 20'ha1500; // 0xa15000-0xa1500f
    localparam logic [23:0] WIN_XFER0    = 24'ha15000;
    localparam logic [23:0] WIN_XFER1    = 24'ha15002;

    // Register window offsets.
    localparam logic [3:0] OFF_XFER0  = 4'h0;
    localparam logic [3:0] OFF_XFER1  = 4'h2;
    localparam logic [3:0] OFF_STATUS = 4'h4;

    // Wake locations in the low 64 KiB of the shared memory.
    localparam logic [15:0] WAKE_A_OFF = 16'hfe06;
    localparam logic [15:0] WAKE_B_OFF = 16'hfe08;

    // Permutation masks.
    localparam logic [15:0] ARR1_KEEP = 16'h7001;
    localparam logic [15:0] ARR1_UP   = 16'h003e;
    localparam logic [15:0] ARR1_DOWN = 16'h0fc0;
    localparam logic [15:0] ARR2_KEEP = 16'h7801;
    localparam logic [15:0] ARR2_UP   = 16'h001e;
    localparam logic [15:0] ARR2_DOWN = 16'h07e0;

    localparam logic [DATA_W-1:0] STATUS_XFER_FULL = 16'h0002;
    localparam logic [DATA_W-1:0] STATUS_CLR_MASK  = 16'hfffe;

    // Decoded access held between the accept cycle and the memory read return.
    typedef struct packed {
        logic              use_ram;
        logic [DATA_W-1:0] value;
        logic              wake_fe06;
        logic              wake_fe08;
        logic              wake_mailbox;
        logic              unmapped;
    } dhpca_stage_t;

    // Word index permutations; w is the byte address shifted right by one.
    function automatic logic [15:0] arrange1(input logic [15:0] w);
        arrange1 = (w & ARR1_KEEP) | ((w & ARR1_UP) << 6) | ((w & ARR1_DOWN) >> 5);
    endfunction

    function automatic logic [15:0] arrange2(input logic [15:0] w);
        arrange2 = (w & ARR2_KEEP) | ((w & ARR2_UP) << 6) | ((w & ARR2_DOWN) >> 4);
    endfunction

endpackage
`default_nettype wire

### rtl/core/dhpca_ram.sv
// Generic single-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dhpca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/core/dsp_host_port_with_cell_arrange.sv
// Top level of the coprocessor host port: decode, register window and shared memory.
`timescale 1ns / 1ps
`default_nettype none
// Host-bus port of a coprocessor. Each transfer on the s_ channel is one bus
// access (16-bit read, 8-bit read or 16-bit write); each produces exactly one
// transfer on the m_ channel carrying the read data and four event flags.
// Shared memory words live at 0x300000-0x31ffff, with two permuted read views
// at 0x390000 and 0x3a0000; the register window at 0xa15000 holds the
// transfer register and the status word.
// The access is decoded and applied to the memory and the registers in the
// cycle it is accepted; the result then passes the decode stage register,
// which also receives the registered memory read, and the output register.
// One access is taken per cycle while the m_ side keeps up.
// When the receiver stalls, one result waits in the output register and one
// more in the decode stage; input is then held off until space frees up.
// Reset (aresetn low, synchronous) empties both stages and clears the
// transfer register and the status word. The memory is not cleared: a word
// reads as undefined until the host has written it.
module dsp_host_port_with_cell_arrange #(
    parameter int RAM_WORDS = dhpca_pkg::RAM_WORDS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata: mode[1:0], address[25:2], write_data[41:26], zero padding
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [dhpca_pkg::S_TDATA_W-1:0]   s_tdata,
    // m_tdata: read_data[15:0], wake_fe06[16], wake_fe08[17], wake_mailbox[18],
    // unmapped[19], zero padding
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [dhpca_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int RAM_AW = $clog2(RAM_WORDS);
    localparam logic [16:0] RAM_WORDS_L = 17'(RAM_WORDS);

    logic [dhpca_pkg::MODE_W-1:0] in_mode;
    logic [dhpca_pkg::ADDR_W-1:0] in_addr;
    logic [dhpca_pkg::DATA_W-1:0] in_wdata;

    logic accept;
    logic advance;

    logic in_ram, in_ram_low, in_arr1, in_arr2, in_win;
    logic [15:0] word_sel;
    logic [16:0] word_ext;
    logic [16:0] word_mod;
    logic [RAM_AW-1:0] ram_addr;
    logic ram_en, ram_we;
    logic [dhpca_pkg::DATA_W-1:0] ram_rdata;

    logic [3:0] win_off;
    logic [dhpca_pkg::DATA_W-1:0] win_word;
    logic win_read, win_write;

    dhpca_pkg::dhpca_stage_t st_next, st_reg;
    logic st_valid_reg, st_valid_next;

    logic out_valid_reg, out_valid_next;
    logic [dhpca_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [dhpca_pkg::DATA_W-1:0] xfer_reg, xfer_next;
    logic [dhpca_pkg::DATA_W-1:0] status_reg, status_next;

    logic [dhpca_pkg::DATA_W-1:0] result_data;

    assign in_mode  = s_tdata[1:0];
    assign in_addr  = s_tdata[25:2];
    assign in_wdata = s_tdata[41:26];

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !st_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Region decode.
    assign in_ram     = in_addr[23:17] == dhpca_pkg::RAM_BASE_HI;
    assign in_ram_low = in_addr[23:16] == dhpca_pkg::RAM_LOW_HI;
    assign in_arr1    = in_addr[23:16] == dhpca_pkg::ARR1_HI;
    assign in_arr2    = in_addr[23:16] == dhpca_pkg::ARR2_HI;
    assign in_win     = in_addr[23:4] == dhpca_pkg::WIN_HI;

    always_comb begin
        priority if (in_arr1 && !in_ram) begin
            word_sel = dhpca_pkg::arrange1(in_addr[16:1]);
        end else if (in_arr2 && !in_ram) begin
            word_sel = dhpca_pkg::arrange2(in_addr[16:1]);
        end else begin
            word_sel = in_addr[16:1];
        end
    end

    // The word index stays below twice the memory depth, so one subtract wraps it.
    assign word_ext = {1'b0, word_sel};
    assign word_mod = (word_ext >= RAM_WORDS_L) ? (word_ext - RAM_WORDS_L) : word_ext;
    assign ram_addr = word_mod[RAM_AW-1:0];

    // Byte reads of the window address the even word and pick a byte afterwards.
    assign win_off = (in_mode == dhpca_pkg::MODE_RD8) ? {in_addr[3:1], 1'b0} : in_addr[3:0];

    always_comb begin
        unique case (win_off)
            dhpca_pkg::OFF_XFER0,
            dhpca_pkg::OFF_XFER1:  win_word = xfer_reg;
            dhpca_pkg::OFF_STATUS: win_word = status_reg;
            default:               win_word = '0;
        endcase
    end

    always_comb begin
        st_next   = '0;
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        win_read  = 1'b0;
        win_write = 1'b0;
        unique case (in_mode)
            dhpca_pkg::MODE_RD16: begin
                if (in_ram || in_arr1 || in_arr2) begin
                    ram_en          = accept;
                    st_next.use_ram = 1'b1;
                end else if (in_win) begin
                    win_read      = 1'b1;
                    st_next.value = win_word;
                end else begin
                    st_next.unmapped = 1'b1;
                end
            end
            dhpca_pkg::MODE_RD8: begin
                if (in_win) begin
                    win_read      = 1'b1;
                    st_next.value = in_addr[0] ? {8'h00, win_word[7:0]}
                                               : {8'h00, win_word[15:8]};
                end else begin
                    st_next.unmapped = 1'b1;
                end
            end
            dhpca_pkg::MODE_WR16: begin
                if (in_ram) begin
                    ram_en = accept;
                    ram_we = 1'b1;
                    if (in_ram_low && in_wdata != '0) begin
                        st_next.wake_fe06 = in_addr[15:0] == dhpca_pkg::WAKE_A_OFF;
                        st_next.wake_fe08 = in_addr[15:0] == dhpca_pkg::WAKE_B_OFF;
                    end
                end else if (in_win) begin
                    if (in_addr == dhpca_pkg::WIN_XFER0 || in_addr == dhpca_pkg::WIN_XFER1) begin
                        win_write            = 1'b1;
                        st_next.wake_mailbox = 1'b1;
                    end
                end else begin
                    st_next.unmapped = 1'b1;
                end
            end
            default: begin
                st_next.unmapped = 1'b1;
            end
        endcase
    end

    // Register window side effects take place in the cycle the access is accepted.
    always_comb begin
        xfer_next   = xfer_reg;
        status_next = status_reg;
        if (accept && win_write) begin
            xfer_next   = in_wdata;
            status_next = status_reg | dhpca_pkg::STATUS_XFER_FULL;
        end else if (accept && win_read && win_off == dhpca_pkg::OFF_STATUS) begin
            status_next = status_reg & dhpca_pkg::STATUS_CLR_MASK;
        end
    end

    dhpca_ram #(
        .WIDTH (dhpca_pkg::DATA_W),
        .DEPTH (RAM_WORDS)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (accept) begin
            st_valid_next = 1'b1;
        end else if (advance) begin
            st_valid_next = 1'b0;
        end else begin
            st_valid_next = st_valid_reg;
        end
    end

    assign result_data = st_reg.use_ram ? ram_rdata : st_reg.value;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance) begin
            out_valid_next = st_valid_reg;
            out_data_next  = {4'h0, st_reg.unmapped, st_reg.wake_mailbox,
                              st_reg.wake_fe08, st_reg.wake_fe06, result_data};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            xfer_reg      <= '0;
            status_reg    <= '0;
        end else begin
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= out_valid_next;
            xfer_reg      <= xfer_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_reg <= st_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the coprocessor host port: random and directed bus accesses.
`timescale 1ns / 1ps
module tb_top;
    import dhpca_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int ACCESS_COUNT = 800;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } host_access_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              wake_fe06;
        logic              wake_fe08;
        logic              wake_mailbox;
        logic              unmapped;
    } access_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    host_access_t   access_q[$];
    access_result_t expected_results[$];
    host_access_t   held_access = '0;

    // Bench image of the block's state.
    logic [DATA_W-1:0] ram_image [RAM_WORDS_DEFAULT];
    logic [DATA_W-1:0] xfer_word = '0;
    logic [DATA_W-1:0] status_word = '0;

    // Which memory words the stimulus has already written.
    bit word_written [RAM_WORDS_DEFAULT];
    int written_slots[$];

    int mismatch_count = 0;
    int stall_cycles = 0;
    int bus_cycle = 0;

    dsp_host_port_with_cell_arrange dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic int ram_slot(logic [ADDR_W-1:0] addr);
        return int'(addr[16:1]) % RAM_WORDS_DEFAULT;
    endfunction

    // The two cell-arrange views reorder bit fields of the word address.
    function automatic logic [15:0] cell_view_a(logic [ADDR_W-1:0] addr);
        logic [15:0] w;
        w = addr[16:1];
        return {1'b0, w[14:12], w[5:1], w[11:6], w[0]};
    endfunction

    function automatic logic [15:0] cell_view_b(logic [ADDR_W-1:0] addr);
        logic [15:0] w;
        w = addr[16:1];
        return {1'b0, w[14:11], w[4:1], w[10:5], w[0]};
    endfunction

    function automatic logic in_ram_range(logic [ADDR_W-1:0] addr);
        return addr >= 24'h300000 && addr <= 24'h31ffff;
    endfunction

    function automatic logic in_window(logic [ADDR_W-1:0] addr);
        return addr[23:4] == WIN_HI;
    endfunction

    // Word read of the register window, including the clear-on-read of status bit 0.
    function automatic logic [DATA_W-1:0] read_window_word(logic [3:0] offset);
        logic [DATA_W-1:0] v;
        v = '0;
        case (offset)
            OFF_XFER0, OFF_XFER1: begin
                v = xfer_word;
            end
            OFF_STATUS: begin
                v = status_word;
                status_word = status_word & STATUS_CLR_MASK;
            end
            default: begin
                v = '0;
            end
        endcase
        return v;
    endfunction

    function automatic access_result_t predict_host_access(host_access_t a);
        access_result_t r;
        logic [DATA_W-1:0] w;
        r = '0;
        case (a.mode)
            MODE_RD16: begin
                if (in_ram_range(a.addr)) begin
                    r.read_data = ram_image[ram_slot(a.addr)];
                end else if (a.addr[23:16] == ARR1_HI) begin
                    r.read_data = ram_image[int'(cell_view_a(a.addr)) % RAM_WORDS_DEFAULT];
                end else if (a.addr[23:16] == ARR2_HI) begin
                    r.read_data = ram_image[int'(cell_view_b(a.addr)) % RAM_WORDS_DEFAULT];
                end else if (in_window(a.addr)) begin
                    r.read_data = read_window_word(a.addr[3:0]);
                end else begin
                    r.unmapped = 1'b1;
                end
            end
            MODE_RD8: begin
                if (in_window(a.addr)) begin
                    w = read_window_word({a.addr[3:1], 1'b0});
                    r.read_data = a.addr[0] ? {8'h00, w[7:0]} : {8'h00, w[15:8]};
                end else begin
                    r.unmapped = 1'b1;
                end
            end
            MODE_WR16: begin
                if (in_ram_range(a.addr)) begin
                    // Wake flags only for the lower 64 KiB and only on non-zero data.
                    if (a.addr[23:16] == RAM_LOW_HI && a.data != '0) begin
                        r.wake_fe06 = a.addr[15:0] == WAKE_A_OFF;
                        r.wake_fe08 = a.addr[15:0] == WAKE_B_OFF;
                    end
                    ram_image[ram_slot(a.addr)] = a.data;
                end else if (in_window(a.addr)) begin
                    if (a.addr == WIN_XFER0 || a.addr == WIN_XFER1) begin
                        xfer_word = a.data;
                        status_word = status_word | STATUS_XFER_FULL;
                        r.wake_mailbox = 1'b1;
                    end
                end else begin
                    r.unmapped = 1'b1;
                end
            end
            default: begin
                r.unmapped = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic void mark_written(int slot);
        if (!word_written[slot]) begin
            word_written[slot] = 1'b1;
            written_slots.push_back(slot);
        end
    endfunction

    // Queues one access; a memory read of a word never written is preceded by a write to it.
    task automatic queue_access(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
        int slot;
        host_access_t fill;
        slot = -1;
        if (mode == MODE_RD16) begin
            if (in_ram_range(addr))
                slot = ram_slot(addr);
            else if (addr[23:16] == ARR1_HI)
                slot = int'(cell_view_a(addr)) % RAM_WORDS_DEFAULT;
            else if (addr[23:16] == ARR2_HI)
                slot = int'(cell_view_b(addr)) % RAM_WORDS_DEFAULT;
        end
        if (slot >= 0 && !word_written[slot]) begin
            fill.mode = MODE_WR16;
            fill.addr = 24'h300000 + {7'd0, slot[15:0], 1'($urandom_range(0, 1))};
            fill.data = 16'($urandom);
            access_q.push_back(fill);
            mark_written(slot);
        end
        if (mode == MODE_WR16 && in_ram_range(addr))
            mark_written(ram_slot(addr));
        access_q.push_back('{mode: mode, addr: addr, data: data});
    endtask

    function automatic logic side_idles();
        return !(bus_cycle >= 300 && bus_cycle < 650) && $urandom_range(0, 99) < 6;
    endfunction

    function automatic void check_field(string field, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s: expected %h, got %h", field, want, got);
        end
    endfunction

    // Driver: presents queued accesses and works out the expected result of each transfer.
    always @(posedge aclk) begin : drive
        host_access_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            bus_cycle <= bus_cycle + 1;
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_host_access(held_access));
            if (!s_tvalid || s_tready) begin
                if (access_q.size() != 0 && !side_idles()) begin
                    nxt = access_q.pop_front();
                    held_access <= nxt;
                    s_tdata <= {6'd0, nxt.data, nxt.addr, nxt.mode};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !side_idles();
        end
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge aclk) begin : monitor
        access_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result with no access outstanding: %h", m_tdata);
            end else begin
                want = expected_results.pop_front();
                check_field("read_data", want.read_data, m_tdata[15:0]);
                check_field("wake_fe06", 16'(want.wake_fe06), 16'(m_tdata[16]));
                check_field("wake_fe08", 16'(want.wake_fe08), 16'(m_tdata[17]));
                check_field("wake_mailbox", 16'(want.wake_mailbox), 16'(m_tdata[18]));
                check_field("unmapped", 16'(want.unmapped), 16'(m_tdata[19]));
            end
        end
    end

    // Watchdog on cycles in which neither channel completes a transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int sel;
        logic [MODE_W-1:0] m;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;

        // Register window from reset, then loaded, with byte and odd-offset reads.
        queue_access(MODE_RD16, 24'ha15000, 16'h0000);
        queue_access(MODE_RD16, 24'ha15004, 16'h0000);
        queue_access(MODE_WR16, 24'ha15000, 16'hffff);
        queue_access(MODE_RD16, 24'ha15004, 16'h0000);
        queue_access(MODE_RD8,  24'ha15000, 16'h0000);
        queue_access(MODE_RD8,  24'ha15001, 16'h0000);
        queue_access(MODE_RD8,  24'ha15005, 16'h0000);
        queue_access(MODE_RD16, 24'ha15001, 16'h0000);
        queue_access(MODE_RD16, 24'ha15003, 16'h0000);
        queue_access(MODE_RD16, 24'ha1500e, 16'h0000);
        queue_access(MODE_WR16, 24'ha15004, 16'h1234);
        queue_access(MODE_WR16, 24'ha15002, 16'h00a5);
        queue_access(MODE_RD16, 24'ha15002, 16'h0000);
        // Wake locations: non-zero, zero, upper half and odd byte address.
        queue_access(MODE_WR16, 24'h30fe06, 16'h0001);
        queue_access(MODE_WR16, 24'h30fe08, 16'h8000);
        queue_access(MODE_WR16, 24'h30fe06, 16'h0000);
        queue_access(MODE_WR16, 24'h31fe06, 16'hbeef);
        queue_access(MODE_WR16, 24'h30fe07, 16'h5555);
        queue_access(MODE_RD16, 24'h30fe06, 16'h0000);
        queue_access(MODE_RD16, 24'h31ffff, 16'h0000);
        // Cell-arrange reads, and the accesses that fall outside the block.
        queue_access(MODE_RD16, 24'h39ffff, 16'h0000);
        queue_access(MODE_RD16, 24'h3a1234, 16'h0000);
        queue_access(MODE_WR16, 24'h390010, 16'h4321);
        queue_access(MODE_RD8,  24'h300000, 16'h0000);
        queue_access(MODE_NONE, 24'ha15000, 16'hffff);
        queue_access(MODE_RD16, 24'h000000, 16'h0000);
        queue_access(MODE_WR16, 24'hffffff, 16'hffff);

        while (access_q.size() < ACCESS_COUNT) begin
            sel = $urandom_range(0, 99);
            d = 16'($urandom);
            if (sel < 28) begin
                a = 24'h300000 + 24'($urandom_range(0, 24'h1ffff));
                if ($urandom_range(0, 7) == 0)
                    a = {7'h18, 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 1) != 0) ? WAKE_A_OFF : WAKE_B_OFF};
                if ($urandom_range(0, 5) == 0)
                    d = '0;
                queue_access(MODE_WR16, a, d);
            end else if (sel < 50) begin
                if (written_slots.size() != 0 && $urandom_range(0, 1) != 0)
                    a = 24'h300000 + {7'd0,
                        written_slots[$urandom_range(0, written_slots.size() - 1)][15:0],
                        1'($urandom_range(0, 1))};
                else
                    a = 24'h300000 + 24'($urandom_range(0, 24'h1ffff));
                queue_access(MODE_RD16, a, d);
            end else if (sel < 62) begin
                a = {($urandom_range(0, 1) != 0) ? ARR1_HI : ARR2_HI, 16'($urandom)};
                queue_access(MODE_RD16, a, d);
            end else if (sel < 78) begin
                m = 2'($urandom_range(0, 2));
                a = {WIN_HI, 4'($urandom)};
                if (m == MODE_WR16 && $urandom_range(0, 1) != 0)
                    a = ($urandom_range(0, 1) != 0) ? WIN_XFER0 : WIN_XFER1;
                queue_access(m, a, d);
            end else if (sel < 86) begin
                // Accesses the decoder turns away: cell-arrange writes and byte reads.
                if ($urandom_range(0, 1) != 0)
                    queue_access(MODE_WR16,
                                 {($urandom_range(0, 1) != 0) ? ARR1_HI : ARR2_HI,
                                  16'($urandom)}, d);
                else
                    queue_access(MODE_RD8, 24'h300000 + 24'($urandom_range(0, 24'h1ffff)), d);
            end else begin
                queue_access(2'($urandom_range(0, 3)), 24'($urandom), d);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // Sampled on the falling edge so that the driver's updates of this cycle have settled.
        while (access_q.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
